// ===== rtl/hpl_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hpl_pkg: shared types and constants of the hash probe lookup
// Word formats, table geometry, hash constants and the slot index helpers.
// ----------------------------------------------------------------------------
package hpl_pkg;

	// table geometry; the depth is a power of two
	localparam int TABLE_DEPTH = 1024;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int MASK_W      = 10;
	localparam int KEY_W       = 32;
	localparam int VAL_W       = 32;
	localparam int SLOT_W      = KEY_W + VAL_W;

	localparam logic [KEY_W-1:0]  HASH_MULT  = 32'h9E37_79B1;
	localparam logic [KEY_W-1:0]  EMPTY_KEY  = '1;
	localparam logic [MASK_W-1:0] MASK_RESET = '1;

	localparam logic MODE_WRITE  = 1'b0;
	localparam logic MODE_LOOKUP = 1'b1;

	// input word
	typedef struct packed {
		logic                    mode;
		logic [MASK_W-1:0]       slot_index;
		logic [KEY_W-1:0]        search_key;
		logic signed [VAL_W-1:0] entry_value;
		logic signed [VAL_W-1:0] missing_value;
	} in_word_t;

	// result word
	typedef struct packed {
		logic                    found;
		logic signed [VAL_W-1:0] result_value;
	} out_word_t;

	// low bits of ((key >> 4) * HASH_MULT); only the low operand bits matter
	function automatic logic [MASK_W-1:0] hash_index(input logic [KEY_W-1:0] key);
		logic [2*MASK_W-1:0] prod;
		prod = key[MASK_W+3:4] * HASH_MULT[MASK_W-1:0];
		return prod[MASK_W-1:0];
	endfunction

	// probe index reduced to a table address
	function automatic logic [ADDR_W-1:0] slot_addr(input logic [MASK_W-1:0] idx);
		logic [MASK_W+ADDR_W-1:0] wide;
		wide = {{ADDR_W{1'b0}}, idx};
		return wide[ADDR_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/hpl_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hpl_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module hpl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/hash_probe_lookup_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hash_probe_lookup_top: linear probing hash table lookup
// Slot writes and key lookups against a key/value table held in one RAM.
// ----------------------------------------------------------------------------
// After reset the block sweeps the table to empty, one slot per cycle, for all
// TABLE_DEPTH (1024) slots with busy high; cfg writes are taken meanwhile.
// A write word is stored at its accepting edge and gives no result. A lookup
// word raises done once its P probes end, where P is the number of slots probed
// (1 up to probe_mask+1): the hash is registered at the accepting edge, ST_READ
// waits out the RAM read latency, then ST_CHECK tests one slot per probe.
// Done is high for a single cycle; out_word holds the result until the next
// lookup probes. The result is taken at the edge that ends the done cycle; the
// next word can be accepted at that same edge. The receiver cannot stall the result.
// ----------------------------------------------------------------------------
module hash_probe_lookup_top
	import hpl_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output      logic              busy,
	input  wire in_word_t          in_word,
	input  wire logic              cfg_we,
	input  wire logic [MASK_W-1:0] cfg_wdata,
	output      logic              done,
	output      out_word_t         out_word
);

	localparam logic [1:0] ST_CLEAR = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_READ  = 2'd2;
	localparam logic [1:0] ST_CHECK = 2'd3;

	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_DEPTH - 1);

	logic [1:0]              state_q;
	logic [ADDR_W-1:0]       clr_cnt_q;
	logic [MASK_W-1:0]       probe_mask_q;
	logic [MASK_W-1:0]       idx_q;
	logic [MASK_W-1:0]       cnt_q;
	logic [KEY_W-1:0]        key_q;
	logic signed [VAL_W-1:0] miss_q;
	logic                    done_q;
	out_word_t               result_q;

	logic                    accept;
	logic [MASK_W-1:0]       next_idx;
	logic                    ram_we;
	logic [ADDR_W-1:0]       ram_waddr;
	logic [SLOT_W-1:0]       ram_wdata;
	logic [ADDR_W-1:0]       ram_raddr;
	logic [SLOT_W-1:0]       ram_rdata;
	logic [KEY_W-1:0]        stored_key;
	logic signed [VAL_W-1:0] stored_val;

	assign busy       = (state_q != ST_IDLE);
	assign accept     = start && !busy;
	assign next_idx   = (idx_q + MASK_W'(1)) & probe_mask_q;
	assign stored_key = ram_rdata[SLOT_W-1:VAL_W];
	assign stored_val = ram_rdata[VAL_W-1:0];
	assign done       = done_q;
	assign out_word   = result_q;

	// RAM port muxing: clearing sweep or slot write; probe reads
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = slot_addr(in_word.slot_index);
		ram_wdata = {in_word.search_key, in_word.entry_value};
		ram_raddr = '0;
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_cnt_q;
			ram_wdata = {EMPTY_KEY, {VAL_W{1'b0}}};
		end else if (accept && in_word.mode == MODE_WRITE) begin
			ram_we = 1'b1;
		end
		case (state_q)
			ST_READ:  ram_raddr = slot_addr(idx_q);
			ST_CHECK: ram_raddr = slot_addr(next_idx);
			default:  ram_raddr = '0;
		endcase
	end

	hpl_ram #(
		.WIDTH(SLOT_W),
		.DEPTH(TABLE_DEPTH)
	) u_slot_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_mask_q <= MASK_RESET;
		end else if (cfg_we) begin
			probe_mask_q <= cfg_wdata;
		end
	end

	// control: clear sweep, hash, probe walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
					if (clr_cnt_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && in_word.mode == MODE_LOOKUP) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (stored_key == EMPTY_KEY || stored_key == key_q
					    || cnt_q == probe_mask_q) begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// lookup datapath: hashed start index, probe count, result word
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept && in_word.mode == MODE_LOOKUP) begin
			idx_q  <= hash_index(in_word.search_key) & probe_mask_q;
			cnt_q  <= '0;
			key_q  <= in_word.search_key;
			miss_q <= in_word.missing_value;
		end else if (state_q == ST_CHECK) begin
			idx_q <= next_idx;
			cnt_q <= cnt_q + MASK_W'(1);
		end
		// empty marker checked first: an all-ones key never hits
		if (state_q == ST_CHECK) begin
			if (stored_key != EMPTY_KEY && stored_key == key_q) begin
				result_q.found        <= 1'b1;
				result_q.result_value <= stored_val;
			end else begin
				result_q.found        <= 1'b0;
				result_q.result_value <= miss_q;
			end
		end
	end

endmodule
`default_nettype wire
